>>> hdl/pearson_r_squared_engine_assert.svh
// ----------------------------------------------------------------------------
// pearson_r_squared_engine_assert.svh
// Assertion macros shared by the engine modules.
// ----------------------------------------------------------------------------
`ifndef PEARSON_R_SQUARED_ENGINE_ASSERT_SVH
`define PEARSON_R_SQUARED_ENGINE_ASSERT_SVH

// same-cycle implication
`define PRSE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define PRSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/prse_pkg.sv
// ----------------------------------------------------------------------------
// prse_pkg
// Shared types and constants for the squared-correlation engine.
// ----------------------------------------------------------------------------
package prse_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int R_W        = 16;
	localparam int STATUS_W   = 2;
	localparam int DIV_STEPS  = 16;
	localparam int DIV_CNT_W  = 4;

	typedef enum logic [STATUS_W-1:0] {
		ST_VALID   = 2'd0,
		ST_FEW     = 2'd1,
		ST_ZEROVAR = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_N_SAA,
		OP_SA_SA,
		OP_N_SBB,
		OP_SB_SB,
		OP_N_SAB,
		OP_SA_SB,
		OP_C_C,
		OP_VA_VB
	} mul_op_t;

	typedef struct packed {
		logic    acc_en;
		logic    clr;
		logic    mul_start;
		mul_op_t mul_op;
		logic    mul_wb;
		logic    q_clr;
		logic    q_sat;
		logic    div_step;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic few;
		logic var_bad;
		logic num_ge_den;
	} dp_sts_t;

endpackage

>>> hdl/pearson_r_squared_engine.sv
// ----------------------------------------------------------------------------
// pearson_r_squared_engine
// Squared Pearson correlation of two streamed signed Q4.8 genotype vectors.
// ----------------------------------------------------------------------------
// Sample pairs are taken one per cycle and accumulated exactly (count, sums,
// sums of squares, cross sum); pairs past MAX_SAMPLES are dropped. After the
// pair flagged last_sample, sample_ready drops for the result phase: up to
// eight products on one shift-add multiplier that retires one multiplier
// bit per cycle (six products when there are fewer than two samples or a
// zero variance), then a compare and 16 restoring division steps (none
// on saturation). r_squared is unsigned Q0.16, truncated and
// saturated at 65535; status is 0 valid, 1 fewer than two samples, 2 zero
// variance (r_squared then 0). The result sits in an output register, so
// the next vector streams in while it waits for transfer.
// ----------------------------------------------------------------------------
module pearson_r_squared_engine import prse_pkg::*; #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic signed [SAMPLE_W-1:0] sample_a,
	input  logic signed [SAMPLE_W-1:0] sample_b,
	input  logic                       last_sample,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [R_W-1:0]             r_squared,
	output logic [STATUS_W-1:0]        status
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	prse_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.last_sample  (last_sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.sts          (sts),
		.cmd          (cmd)
	);

	prse_dp #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_a  (sample_a),
		.sample_b  (sample_b),
		.cmd       (cmd),
		.sts       (sts),
		.r_squared (r_squared)
	);

endmodule

>>> hdl/prse_mul.sv
// ----------------------------------------------------------------------------
// prse_mul
// Sequential shift-add multiplier on operand magnitudes, one bit per cycle.
// ----------------------------------------------------------------------------
module prse_mul #(
	parameter int MW = 50
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [MW-1:0] op_a,
	input  logic signed [MW-1:0] op_b,
	output logic                 busy,
	output logic [2*MW-1:0]      mag,
	output logic                 neg
);

	localparam int PW = 2 * MW;

	logic [MW-1:0] abs_a;
	logic [MW-1:0] abs_b;
	logic [PW-1:0] mcand_q;
	logic [MW-1:0] mplier_q;
	logic [PW-1:0] mag_q;
	logic          neg_q;

	assign abs_a = op_a[MW-1] ? (~$unsigned(op_a) + MW'(1)) : $unsigned(op_a);
	assign abs_b = op_b[MW-1] ? (~$unsigned(op_b) + MW'(1)) : $unsigned(op_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mplier_q <= '0;
		end else if (start) begin
			mplier_q <= abs_b;
		end else if (|mplier_q) begin
			mplier_q <= mplier_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= PW'(abs_a);
			mag_q   <= '0;
			neg_q   <= op_a[MW-1] ^ op_b[MW-1];
		end else if (|mplier_q) begin
			if (mplier_q[0]) begin
				mag_q <= mag_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
		end
	end

	assign busy = |mplier_q;
	assign mag  = mag_q;
	assign neg  = neg_q;

endmodule

>>> hdl/prse_dp.sv
// ----------------------------------------------------------------------------
// prse_dp
// Datapath: moment accumulators, variance terms, multiplier and divider.
// ----------------------------------------------------------------------------
`include "pearson_r_squared_engine_assert.svh"

module prse_dp import prse_pkg::*; #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic signed [SAMPLE_W-1:0] sample_a,
	input  logic signed [SAMPLE_W-1:0] sample_b,
	input  dp_cmd_t                    cmd,
	output dp_sts_t                    sts,
	output logic [R_W-1:0]             r_squared
);

	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int SW  = SAMPLE_W + CW;
	localparam int SQW = 2 * SAMPLE_W - 2 + CW;
	localparam int XW  = 2 * SAMPLE_W - 1 + CW;
	localparam int VW  = CW + XW + 1;
	localparam int PW  = 2 * VW;
	localparam int RW  = PW + 1;

	logic [CW-1:0]                count_q;
	logic signed [SW-1:0]         sum_a_q;
	logic signed [SW-1:0]         sum_b_q;
	logic [SQW-1:0]               sum_sq_a_q;
	logic [SQW-1:0]               sum_sq_b_q;
	logic signed [XW-1:0]         sum_cross_q;
	logic signed [2*SAMPLE_W-1:0] prod_aa;
	logic signed [2*SAMPLE_W-1:0] prod_bb;
	logic signed [2*SAMPLE_W-1:0] prod_ab;

	logic signed [VW-1:0] n_v;
	logic signed [VW-1:0] saa_v;
	logic signed [VW-1:0] sbb_v;
	logic signed [VW-1:0] sab_v;
	logic signed [VW-1:0] sa_v;
	logic signed [VW-1:0] sb_v;
	logic signed [VW-1:0] mop_a;
	logic signed [VW-1:0] mop_b;
	logic                 mul_busy;
	logic [PW-1:0]        mul_mag;
	logic                 mul_neg;
	logic signed [VW-1:0] prod_v;

	logic signed [VW-1:0] t_q;
	logic signed [VW-1:0] va_q;
	logic signed [VW-1:0] vb_q;
	logic signed [VW-1:0] cv_q;
	logic [RW-1:0]        rem_q;
	logic [PW-1:0]        den_q;
	logic [RW-1:0]        rem_sh;
	logic                 step_ge;
	logic [R_W-1:0]       q_q;
	logic [R_W-1:0]       r_squared_q;

	assign prod_aa = sample_a * sample_a;
	assign prod_bb = sample_b * sample_b;
	assign prod_ab = sample_a * sample_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			sum_sq_a_q  <= '0;
			sum_sq_b_q  <= '0;
			sum_cross_q <= '0;
		end else if (cmd.clr) begin
			count_q     <= '0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			sum_sq_a_q  <= '0;
			sum_sq_b_q  <= '0;
			sum_cross_q <= '0;
		end else if (cmd.acc_en && (count_q < CW'(MAX_SAMPLES))) begin
			count_q     <= count_q + CW'(1);
			sum_a_q     <= sum_a_q + SW'(sample_a);
			sum_b_q     <= sum_b_q + SW'(sample_b);
			sum_sq_a_q  <= sum_sq_a_q + SQW'($unsigned(prod_aa));
			sum_sq_b_q  <= sum_sq_b_q + SQW'($unsigned(prod_bb));
			sum_cross_q <= sum_cross_q + XW'(prod_ab);
		end
	end

	assign n_v   = $signed(VW'(count_q));
	assign saa_v = $signed(VW'(sum_sq_a_q));
	assign sbb_v = $signed(VW'(sum_sq_b_q));
	assign sab_v = VW'(sum_cross_q);
	assign sa_v  = VW'(sum_a_q);
	assign sb_v  = VW'(sum_b_q);

	always_comb begin
		case (cmd.mul_op)
			OP_N_SAA: begin mop_a = n_v;  mop_b = saa_v; end
			OP_SA_SA: begin mop_a = sa_v; mop_b = sa_v;  end
			OP_N_SBB: begin mop_a = n_v;  mop_b = sbb_v; end
			OP_SB_SB: begin mop_a = sb_v; mop_b = sb_v;  end
			OP_N_SAB: begin mop_a = n_v;  mop_b = sab_v; end
			OP_SA_SB: begin mop_a = sa_v; mop_b = sb_v;  end
			OP_C_C:   begin mop_a = cv_q; mop_b = cv_q;  end
			OP_VA_VB: begin mop_a = va_q; mop_b = vb_q;  end
			default:  begin mop_a = '0;   mop_b = '0;    end
		endcase
	end

	prse_mul #(
		.MW(VW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.op_a   (mop_a),
		.op_b   (mop_b),
		.busy   (mul_busy),
		.mag    (mul_mag),
		.neg    (mul_neg)
	);

	assign prod_v = $signed(mul_neg ? (~VW'(mul_mag) + VW'(1)) : VW'(mul_mag));

	assign rem_sh  = {rem_q[RW-2:0], 1'b0};
	assign step_ge = rem_sh >= RW'(den_q);

	always_ff @(posedge clk) begin
		if (cmd.mul_wb) begin
			case (cmd.mul_op) inside
				OP_N_SAA, OP_N_SBB, OP_N_SAB: t_q <= prod_v;
				OP_SA_SA: va_q  <= t_q - prod_v;
				OP_SB_SB: vb_q  <= t_q - prod_v;
				OP_SA_SB: cv_q  <= t_q - prod_v;
				OP_C_C:   rem_q <= RW'(mul_mag);
				OP_VA_VB: den_q <= mul_mag;
				default:  ;
			endcase
		end
		if (cmd.q_clr) begin
			q_q <= '0;
		end else if (cmd.q_sat) begin
			q_q <= '1;
		end else if (cmd.div_step) begin
			rem_q <= step_ge ? (rem_sh - RW'(den_q)) : rem_sh;
			q_q   <= {q_q[R_W-2:0], step_ge};
		end
		if (cmd.out_load) begin
			r_squared_q <= q_q;
		end
	end

	assign sts.mul_busy   = mul_busy;
	assign sts.few        = count_q < CW'(2);
	assign sts.var_bad    = va_q[VW-1] || (va_q == '0) || vb_q[VW-1] || (vb_q == '0);
	assign sts.num_ge_den = rem_q >= RW'(den_q);
	assign r_squared      = r_squared_q;

	`PRSE_ASSERT_IMPLY(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(MAX_SAMPLES))
	`PRSE_ASSERT_IMPLY(a_start_free, clk, arst_n, cmd.mul_start, !mul_busy)
	`PRSE_ASSERT_NEXT(a_clear_count, clk, arst_n, cmd.clr, count_q == '0)

endmodule

>>> hdl/prse_ctrl.sv
// ----------------------------------------------------------------------------
// prse_ctrl
// Controller: sequences accumulation, product terms, division and result.
// ----------------------------------------------------------------------------
`include "pearson_r_squared_engine_assert.svh"

module prse_ctrl import prse_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic                last_sample,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [STATUS_W-1:0] status,
	input  dp_sts_t             sts,
	output dp_cmd_t             cmd
);

	typedef enum logic [2:0] {
		S_ACC,
		S_MUL,
		S_WAIT,
		S_CHECK,
		S_CMP,
		S_DIV,
		S_DONE
	} state_t;

	state_t                state_q;
	mul_op_t               op_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	status_t               stat_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  result_valid_q;
	logic                  accept;

	assign accept = sample_valid && (state_q == S_ACC);

	always_comb begin
		cmd        = '0;
		cmd.mul_op = op_q;
		unique case (state_q)
			S_ACC:   cmd.acc_en    = accept;
			S_MUL:   cmd.mul_start = 1'b1;
			S_WAIT:  cmd.mul_wb    = !sts.mul_busy;
			S_CHECK: cmd.q_clr     = 1'b1;
			S_CMP:   cmd.q_sat     = sts.num_ge_den;
			S_DIV:   cmd.div_step  = 1'b1;
			S_DONE: begin
				cmd.out_load = !result_valid_q || result_ready;
				cmd.clr      = !result_valid_q || result_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_ACC;
			op_q           <= OP_N_SAA;
			div_cnt_q      <= '0;
			stat_q         <= ST_VALID;
			status_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready && !cmd.out_load) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_ACC: begin
					if (accept && last_sample) begin
						op_q    <= OP_N_SAA;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_WAIT;
				S_WAIT: begin
					if (!sts.mul_busy) begin
						if (op_q == OP_SA_SB) begin
							state_q <= S_CHECK;
						end else if (op_q == OP_VA_VB) begin
							state_q <= S_CMP;
						end else begin
							op_q    <= mul_op_t'(op_q + 3'd1);
							state_q <= S_MUL;
						end
					end
				end
				S_CHECK: begin
					if (sts.few) begin
						stat_q  <= ST_FEW;
						state_q <= S_DONE;
					end else if (sts.var_bad) begin
						stat_q  <= ST_ZEROVAR;
						state_q <= S_DONE;
					end else begin
						stat_q  <= ST_VALID;
						op_q    <= OP_C_C;
						state_q <= S_MUL;
					end
				end
				S_CMP: begin
					if (sts.num_ge_den) begin
						state_q <= S_DONE;
					end else begin
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (cmd.out_load) begin
						result_valid_q <= 1'b1;
						status_q       <= stat_q;
						state_q        <= S_ACC;
					end
				end
				default: state_q <= S_ACC;
			endcase
		end
	end

	assign sample_ready = (state_q == S_ACC);
	assign result_valid = result_valid_q;
	assign status       = status_q;

	`PRSE_ASSERT_NEXT(a_start_wait, clk, arst_n, cmd.mul_start, state_q == S_WAIT)
	`PRSE_ASSERT_NEXT(a_div_len, clk, arst_n, state_q == S_DIV && div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1), state_q == S_DONE)
	`PRSE_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.out_load, result_valid_q && state_q == S_ACC)

endmodule
